// ----- design/wto_pkg.sv -----
// Shared constants, codes and types for the wavetable oscillator.
`default_nettype none

package wto_pkg;

  // Fixed field widths of the item and register formats.
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 14;
  localparam int DATA_W   = 16;
  localparam int STEP_W   = 30;
  localparam int SIZE_W   = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = STEP_W;

  // Number formats.
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int TABLE_DEPTH_DEF = 16384;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(24348481);
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(16384);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE       = 2'd0,
    CMD_SAMPLE      = 2'd1,
    CMD_RESET_PHASE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 1'd0,
    REG_TABLE_SIZE = 1'd1
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage : wto_pkg

`default_nettype wire

// ----- design/wto_chan_if.sv -----
// Valid/ready channel interfaces for the request and sample streams.
`default_nettype none

interface wto_req_if;
  logic                              valid;
  logic                              ready;
  logic [wto_pkg::CMD_W-1:0]         cmd;
  logic [wto_pkg::ADDR_W-1:0]        addr;
  logic signed [wto_pkg::DATA_W-1:0] data;

  modport source (output valid, output cmd, output addr, output data, input ready);
  modport sink   (input valid, input cmd, input addr, input data, output ready);
endinterface : wto_req_if

interface wto_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [wto_pkg::DATA_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface : wto_rsp_if

`default_nettype wire

// ----- design/wto_table.sv -----
// Wave table memory: one write port, two registered read ports.
`default_nettype none

module wto_table #(
  parameter int DEPTH = wto_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                logic clk,
  input  wire                                logic we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire wto_pkg::sample_t              wdata,
  input  wire                                logic re,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr_b,
  output wto_pkg::sample_t                   rdata_a,
  output wto_pkg::sample_t                   rdata_b
);

  wto_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data held while re is low (no sample read accepted, e.g. under a downstream stall).
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule : wto_table

`default_nettype wire

// ----- design/wavetable_oscillator_interp_top.sv -----
// Top level of the wavetable oscillator with linear interpolation.
`default_nettype none

// Wavetable oscillator. Each request beat on req either writes one table
// entry (cmd WRITE), asks for one interpolated sample (cmd SAMPLE) or clears
// the phase (cmd RESET_PHASE); only SAMPLE beats give a beat on rsp. The
// block takes one request beat every cycle, stalling only when rsp backs
// up. At accept a sample reads the two neighboring entries into the
// dual-read table memory's registered outputs and advances the phase; the
// single 17x17 interpolation multiply then feeds the output register. The
// phase update (clamp, add, wrap) finishes in the accept cycle, so
// back-to-back samples need no bubbles. The table holds TABLE_DEPTH entries,
// is not cleared at reset and must be written before it is read. Registers
// (phase_step, table_size) are written via cfg_we, cfg_index, cfg_data; the
// user must write them only while the block is idle; it does not enforce this.
module wavetable_oscillator_interp_top #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  wto_req_if.sink                               req,
  wto_rsp_if.source                             rsp,
  input  wire logic                             cfg_we,
  input  wire logic [wto_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wto_pkg::CFG_W-1:0]        cfg_data
);

  localparam int F  = wto_pkg::FRAC_BITS;
  localparam int SB = wto_pkg::SAMPLE_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);     // table index bits
  localparam int NW = IW + 1;                  // holds table size itself
  localparam int PW = IW + F;                  // phase bits
  localparam int LW = PW + 1;                  // limit = n << F
  localparam int CW = (LW > wto_pkg::STEP_W) ? LW : wto_pkg::STEP_W;
  localparam int MW = 2 * (SB + 1);            // product width

  // Configuration registers
  logic [wto_pkg::STEP_W-1:0] phase_step;
  logic [wto_pkg::SIZE_W-1:0] table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= wto_pkg::PHASE_STEP_RST;
      table_size <= wto_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wto_pkg::REG_PHASE_STEP: phase_step <= cfg_data[wto_pkg::STEP_W-1:0];
        wto_pkg::REG_TABLE_SIZE: table_size <= cfg_data[wto_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake / pipeline control
  logic s1_valid;
  logic out_valid;
  logic out_free;
  logic en1;
  logic req_fire;
  logic is_write;
  logic is_sample;
  logic is_reset;

  assign out_free  = !out_valid || rsp.ready;
  assign en1       = !s1_valid || out_free;
  assign req.ready = en1;
  assign req_fire  = req.valid && en1;
  assign is_write  = req.cmd == wto_pkg::CMD_WRITE;
  assign is_sample = req.cmd == wto_pkg::CMD_SAMPLE;
  assign is_reset  = req.cmd == wto_pkg::CMD_RESET_PHASE;

  // Effective table size, clamped to [2, TABLE_DEPTH]
  logic [31:0]    ts_ext;
  logic [NW-1:0]  n;
  logic [LW-1:0]  limit;

  assign ts_ext = 32'(table_size);

  always_comb begin
    if (ts_ext < 32'd2) begin
      n = NW'(2);
    end else if (ts_ext > 32'(TABLE_DEPTH)) begin
      n = NW'(TABLE_DEPTH);
    end else begin
      n = NW'(table_size);
    end
  end

  assign limit = {n, {F{1'b0}}};

  // Phase path: clamp step, drop stale phase, advance and wrap
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [CW-1:0] step_ext;
  logic [CW-1:0] limit_ext;
  logic [CW-1:0] step_clamped;
  logic [PW-1:0] step_use;
  logic [PW-1:0] p;
  logic [LW-1:0] sum_w;
  logic [LW-1:0] wrap_w;

  assign step_ext     = CW'(phase_step);
  assign limit_ext    = CW'(limit);
  assign step_clamped = (step_ext >= limit_ext) ? (limit_ext - CW'(1)) : step_ext;
  assign step_use     = step_clamped[PW-1:0];
  assign p            = ({1'b0, phase} >= limit) ? '0 : phase;
  assign sum_w        = {1'b0, p} + {1'b0, step_use};
  assign wrap_w       = (sum_w >= limit) ? (sum_w - limit) : sum_w;
  assign phase_next   = wrap_w[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (req_fire && is_sample) begin
      phase <= phase_next;
    end else if (req_fire && is_reset) begin
      phase <= '0;
    end
  end

  // Neighbor indexes
  logic [IW-1:0] idx_i;
  logic [NW-1:0] idx_j_w;
  logic [IW-1:0] idx_j;

  assign idx_i   = p[PW-1:F];
  assign idx_j_w = {1'b0, idx_i} + NW'(1);
  assign idx_j   = (idx_j_w >= n) ? '0 : idx_j_w[IW-1:0];

  // Table: writes land at accept, sample reads registered at accept
  logic             tbl_we;
  logic             tbl_re;
  wto_pkg::sample_t s1_a;
  wto_pkg::sample_t s1_b;

  assign tbl_we = req_fire && is_write && (32'(req.addr) < 32'(TABLE_DEPTH));
  assign tbl_re = req_fire && is_sample;

  wto_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (IW'(req.addr)),
    .wdata   (req.data[SB-1:0]),
    .re      (tbl_re),
    .raddr_a (idx_i),
    .raddr_b (idx_j),
    .rdata_a (s1_a),
    .rdata_b (s1_b)
  );

  // Stage 1: fraction alongside the read data
  logic [F-1:0] s1_frac;

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      s1_frac <= p[F-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= req_fire && is_sample;
    end
  end

  // Interpolation: s1 + round((s2 - s1) * f / 2^F), half up
  logic signed [SB:0]   diff;
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] prod_rnd;
  logic signed [MW-1:0] prod_sh;
  logic signed [SB:0]   interp;

  assign diff     = {s1_b[SB-1], s1_b} - {s1_a[SB-1], s1_a};
  assign prod     = MW'(diff) * MW'($signed({1'b0, s1_frac}));
  assign prod_rnd = prod + (MW'(1) <<< (F - 1));
  assign prod_sh  = prod_rnd >>> F;
  assign interp   = prod_sh[SB:0] + {s1_a[SB-1], s1_a};

  // Output register
  wto_pkg::sample_t out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_sample <= interp[SB-1:0];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_sample = wto_pkg::DATA_W'(out_sample);

`ifndef ASSERT_OFF
  // A sample request always lands in stage 1.
  a_sample_enters: assert property (@(posedge clk) disable iff (rst)
    req_fire && is_sample |=> s1_valid)
    else $error("sample request lost before stage 1");

  // Phase stays inside the table after a sample step.
  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    req_fire && is_sample |=> ({1'b0, phase} < $past(limit)))
    else $error("phase left the table range");

  // No result appears without a stage-1 item behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output beat without source item");

  // A stalled stage 1 keeps its item.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_frac))
    else $error("stage 1 dropped an item under stall");
`endif

endmodule : wavetable_oscillator_interp_top

`default_nettype wire
